// ===== rtl/ghp_pkg.sv =====
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared sizes, codes and types of the generational handle pool.
// ----------------------------------------------------------------------------
package ghp_pkg;

  localparam int SLOTS    = 256;
  localparam int GEN_BITS = 32;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DEAD  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STALE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

  typedef struct packed {
    logic                alive;
    logic [GEN_BITS-1:0] gen;
  } slot_rec_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_rec_t        data;
  } gen_wr_t;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [GEN_BITS-1:0] gen;
  } stk_entry_t;

  typedef struct packed {
    logic       pop;
    logic       push;
    stk_entry_t entry;
  } stk_ctl_t;

  typedef struct packed {
    stk_entry_t       top;
    logic [CNT_W-1:0] depth;
  } stk_stat_t;

endpackage

// ===== rtl/ghp_if.sv =====
// ----------------------------------------------------------------------------
// ghp_in_if / ghp_out_if
// Valid/ready channels for pool requests and pool results.
// ----------------------------------------------------------------------------
interface ghp_in_if;
  logic                          valid;
  logic                          ready;
  logic [ghp_pkg::OP_W-1:0]      operation;
  logic [ghp_pkg::IDX_W-1:0]     handle_index;
  logic [ghp_pkg::GEN_BITS-1:0]  handle_generation;

  modport source (output valid, operation, handle_index, handle_generation, input ready);
  modport sink   (input valid, operation, handle_index, handle_generation, output ready);
endinterface

interface ghp_out_if;
  logic                          valid;
  logic                          ready;
  logic [ghp_pkg::STATUS_W-1:0]  status;
  logic [ghp_pkg::IDX_W-1:0]     result_index;
  logic [ghp_pkg::GEN_BITS-1:0]  result_generation;
  logic [ghp_pkg::CNT_W-1:0]     live_slots;

  modport source (output valid, status, result_index, result_generation, live_slots,
                  input ready);
  modport sink   (input valid, status, result_index, result_generation, live_slots,
                  output ready);
endinterface

// ===== rtl/generational_handle_pool_unit.sv =====
// ----------------------------------------------------------------------------
// generational_handle_pool_unit
// Slot pool handing out (index, generation) handles: create, free, check.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields                                          Handshake
//  in_chan   in   operation, handle_index, handle_generation      valid/ready
//  out_chan  out  status, result_index, result_generation,        valid/ready
//                 live_slots
//
// One request is taken per cycle unless the result stalls; it passes through
// the request register and then the result register. The request register
// reads the slot memory (generation and alive flag), and the single execute
// step updates the slot state and loads the result register.
// Reset is synchronous and empties the pool at once; slots at or above the
// high-water mark are never read, so the slot memory needs no clearing pass.
// A stalled result holds the execute step, and the input stalls only when
// both the request and the result registers are full.
module generational_handle_pool_unit (
  input  logic     clk,
  input  logic     rst_n,
  ghp_in_if.sink   in_chan,
  ghp_out_if.source out_chan
);

  // request register
  logic                         s1_valid_r;
  logic [ghp_pkg::OP_W-1:0]     s1_op_r;
  logic [ghp_pkg::IDX_W-1:0]    s1_idx_r;
  logic [ghp_pkg::GEN_BITS-1:0] s1_gen_r;

  // pool state
  logic [ghp_pkg::CNT_W-1:0]    hw_r, hw_nxt;
  logic [ghp_pkg::CNT_W-1:0]    total_r, total_nxt;

  // result register
  logic                            out_valid_r;
  logic [ghp_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic [ghp_pkg::IDX_W-1:0]       ridx_r, ridx_nxt;
  logic [ghp_pkg::GEN_BITS-1:0]    rgen_r, rgen_nxt;
  logic [ghp_pkg::CNT_W-1:0]       live_r;

  logic accept, advance;
  ghp_pkg::slot_rec_t           rd_rec;
  logic [ghp_pkg::GEN_BITS-1:0] new_gen;
  logic [ghp_pkg::IDX_W-1:0]    slot;
  ghp_pkg::gen_wr_t             gen_wr, gen_wr_q;
  ghp_pkg::stk_ctl_t            stk_ctl, stk_ctl_q;
  ghp_pkg::stk_stat_t           stk;

  assign advance      = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;
  assign accept       = in_chan.valid && in_chan.ready;

  ghp_gen_store u_gen (
    .clk     (clk),
    .wr      (gen_wr_q),
    .rd_en   (accept),
    .rd_addr (in_chan.handle_index),
    .rd_data (rd_rec)
  );

  ghp_free_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (stk_ctl_q),
    .stat  (stk)
  );

  // Execute step for the request in s1.
  always_comb begin
    status_nxt = ghp_pkg::ST_OK;
    ridx_nxt   = s1_idx_r;
    rgen_nxt   = '0;
    hw_nxt     = hw_r;
    total_nxt  = total_r;
    slot       = s1_idx_r;
    new_gen    = rd_rec.gen + ghp_pkg::GEN_BITS'(1);
    gen_wr     = '0;
    stk_ctl    = '0;
    unique case (s1_op_r) inside
      ghp_pkg::OP_CREATE: begin
        if (stk.depth != '0) begin
          // A freed slot keeps its generation from the free until reuse.
          slot        = stk.top.idx;
          new_gen     = stk.top.gen + ghp_pkg::GEN_BITS'(1);
          stk_ctl.pop = 1'b1;
        end else if (hw_r < ghp_pkg::CNT_W'(ghp_pkg::SLOTS)) begin
          // A never-used slot still has generation zero.
          slot    = hw_r[ghp_pkg::IDX_W-1:0];
          new_gen = ghp_pkg::GEN_BITS'(1);
          hw_nxt  = hw_r + ghp_pkg::CNT_W'(1);
        end else begin
          status_nxt = ghp_pkg::ST_FULL;
        end
        if (status_nxt == ghp_pkg::ST_OK) begin
          gen_wr.en         = 1'b1;
          gen_wr.addr       = slot;
          gen_wr.data.alive = 1'b1;
          gen_wr.data.gen   = new_gen;
          total_nxt         = total_r + ghp_pkg::CNT_W'(1);
          ridx_nxt          = slot;
          rgen_nxt          = new_gen;
        end else begin
          ridx_nxt = '0;
        end
      end
      ghp_pkg::OP_FREE, ghp_pkg::OP_CHECK: begin
        if ({1'b0, s1_idx_r} >= hw_r) begin
          status_nxt = ghp_pkg::ST_RANGE;
        end else begin
          if (!rd_rec.alive) begin
            status_nxt = ghp_pkg::ST_DEAD;
          end else if (rd_rec.gen != s1_gen_r) begin
            status_nxt = ghp_pkg::ST_STALE;
          end
          rgen_nxt = rd_rec.gen;
          if (s1_op_r == ghp_pkg::OP_FREE && status_nxt == ghp_pkg::ST_OK &&
              stk.depth < ghp_pkg::CNT_W'(ghp_pkg::SLOTS)) begin
            gen_wr.en         = 1'b1;
            gen_wr.addr       = s1_idx_r;
            gen_wr.data.alive = 1'b0;
            gen_wr.data.gen   = new_gen;
            stk_ctl.push      = 1'b1;
            stk_ctl.entry.idx = s1_idx_r;
            stk_ctl.entry.gen = new_gen;
            if (total_r != '0) begin
              total_nxt = total_r - ghp_pkg::CNT_W'(1);
            end
            rgen_nxt = new_gen;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State changes take effect only when the request actually executes.
  always_comb begin
    gen_wr_q        = gen_wr;
    gen_wr_q.en     = gen_wr.en && advance;
    stk_ctl_q       = stk_ctl;
    stk_ctl_q.pop   = stk_ctl.pop && advance;
    stk_ctl_q.push  = stk_ctl.push && advance;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hw_r        <= '0;
      total_r     <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        hw_r    <= hw_nxt;
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r  <= in_chan.operation;
      s1_idx_r <= in_chan.handle_index;
      s1_gen_r <= in_chan.handle_generation;
    end
    if (advance) begin
      status_r <= status_nxt;
      ridx_r   <= ridx_nxt;
      rgen_r   <= rgen_nxt;
      live_r   <= total_nxt;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.status            = status_r;
  assign out_chan.result_index      = ridx_r;
  assign out_chan.result_generation = rgen_r;
  assign out_chan.live_slots        = live_r;

`ifndef ASSERT_OFF
  // Every slot below the high-water mark is either alive or on the free stack.
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (stk.depth + total_r) == hw_r)
    else $error("alive count and free depth do not add up to high water");

  // The pool can only be full when every slot is alive.
  a_full_means_all_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && status_nxt == ghp_pkg::ST_FULL) |-> total_r == ghp_pkg::CNT_W'(ghp_pkg::SLOTS))
    else $error("pool full reported while slots remain");

  // An executed request always lands in the result register.
  a_advance_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("executed request did not produce a result");

  // The input only stalls when both stages hold a request.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (s1_valid_r && out_valid_r && !out_chan.ready))
    else $error("input stalled without a full pipeline");
`endif

endmodule

// ===== rtl/ghp_gen_store.sv =====
// ----------------------------------------------------------------------------
// ghp_gen_store
// Per-slot generation and alive flag memory with a registered read and
// write bypass.
// ----------------------------------------------------------------------------
module ghp_gen_store (
  input  logic                      clk,
  input  ghp_pkg::gen_wr_t          wr,
  input  logic                      rd_en,
  input  logic [ghp_pkg::IDX_W-1:0] rd_addr,
  output ghp_pkg::slot_rec_t        rd_data
);

  // Slots at or above the high-water mark are never read, and every slot
  // below it was written when it was first created, so no reset is needed.
  ghp_pkg::slot_rec_t mem [ghp_pkg::SLOTS];
  ghp_pkg::slot_rec_t rd_r;
  ghp_pkg::slot_rec_t byp_data_r;
  logic               byp_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // A read issued in the same cycle as a write to that slot sees the old
  // contents, so the new value is captured alongside and selected instead.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r       <= mem[rd_addr];
      byp_r      <= wr.en && (wr.addr == rd_addr);
      byp_data_r <= wr.data;
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_r;

endmodule

// ===== rtl/ghp_free_stack.sv =====
// ----------------------------------------------------------------------------
// ghp_free_stack
// LIFO of freed slots, each with the generation it was given when freed.
// ----------------------------------------------------------------------------
module ghp_free_stack (
  input  logic               clk,
  input  logic               rst_n,
  input  ghp_pkg::stk_ctl_t  ctl,
  output ghp_pkg::stk_stat_t stat
);

  ghp_pkg::stk_entry_t mem [ghp_pkg::SLOTS];
  ghp_pkg::stk_entry_t top_r, top_nxt;
  ghp_pkg::stk_entry_t sec_r;
  logic [ghp_pkg::CNT_W-1:0] depth_r, depth_nxt;
  logic [ghp_pkg::CNT_W-1:0] sec_addr;

  // The top entry lives in flops; sec_r always holds the entry just below
  // it, prefetched from memory so that back-to-back pops need no wait.
  always_comb begin
    depth_nxt = depth_r;
    top_nxt   = top_r;
    if (ctl.push) begin
      depth_nxt = depth_r + ghp_pkg::CNT_W'(1);
      top_nxt   = ctl.entry;
    end else if (ctl.pop) begin
      depth_nxt = depth_r - ghp_pkg::CNT_W'(1);
      top_nxt   = sec_r;
    end
    sec_addr = depth_nxt - ghp_pkg::CNT_W'(2);
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[depth_r[ghp_pkg::IDX_W-1:0]] <= ctl.entry;
    end
    sec_r <= mem[sec_addr[ghp_pkg::IDX_W-1:0]];
    top_r <= top_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  assign stat.top   = top_r;
  assign stat.depth = depth_r;

endmodule
